// ----- rtl/core/framed_packet_checksum_decoder_assert.svh -----
// Assertion macros for the framed packet checksum decoder.
// No dependencies; included by the top level of the block.
`ifndef FRAMED_PACKET_CHECKSUM_DECODER_ASSERT_SVH
`define FRAMED_PACKET_CHECKSUM_DECODER_ASSERT_SVH

// Antecedent and consequent in the same cycle.
`define FPCD_ASSERT_SAME(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Consequent in the cycle after the antecedent.
`define FPCD_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ----- rtl/core/fpcd_pkg.sv -----
// Shared types and constants of the framed packet checksum decoder.
// No dependencies; used by the parser, the output stage and the top level.
package fpcd_pkg;

   localparam logic [7:0] START_MARK = 8'hAA;
   localparam logic [7:0] END_MARK   = 8'h55;

   typedef enum logic [7:0] {
      PH_START  = 8'b0000_0001,
      PH_MODEL  = 8'b0000_0010,
      PH_IDENT  = 8'b0000_0100,
      PH_LENGTH = 8'b0000_1000,
      PH_DATA   = 8'b0001_0000,
      PH_SUMHI  = 8'b0010_0000,
      PH_SUMLO  = 8'b0100_0000,
      PH_END    = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic [7:0] payload_index;
      logic       payload_valid;
      logic [7:0] frame_length;
      logic [7:0] frame_ident;
      logic [7:0] frame_model;
      logic       frame_good;
   } result_type;

   typedef struct packed {
      logic out_valid;
      logic skid_valid;
   } stage_status_type;

endpackage

// ----- rtl/core/fpcd_parser.sv -----
// Frame parser of the framed packet checksum decoder: phase register, header
// fields, payload counter and running sum. Depends on fpcd_pkg.
module fpcd_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  logic [7:0]           rx_byte,
   output fpcd_pkg::result_type result
);
   import fpcd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  model_ff, model_in;
   logic [7:0]  ident_ff, ident_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  count_ff, count_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  sum_high_ff, sum_high_in;
   logic [7:0]  sum_low_ff, sum_low_in;
   logic        decoded_ff, decoded_in;
   logic [7:0]  count_plus;

   assign count_plus = count_ff + 8'd1;

   always_comb begin
      phase_in    = phase_ff;
      model_in    = model_ff;
      ident_in    = ident_ff;
      length_in   = length_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      sum_high_in = sum_high_ff;
      sum_low_in  = sum_low_ff;
      decoded_in  = decoded_ff;
      result.payload_valid = 1'b0;
      result.payload_index = 8'd0;
      result.payload_byte  = 8'd0;
      unique case (phase_ff)
         PH_START: begin
            decoded_in = 1'b0;
            if (rx_byte == START_MARK) begin
               phase_in = PH_MODEL;
            end
         end
         PH_MODEL: begin
            model_in = rx_byte;
            phase_in = PH_IDENT;
         end
         PH_IDENT: begin
            ident_in = rx_byte;
            phase_in = PH_LENGTH;
         end
         PH_LENGTH: begin
            length_in = rx_byte;
            count_in  = 8'd0;
            sum_in    = 16'd0;
            // An empty payload goes straight on to the checksum bytes.
            phase_in  = (rx_byte == 8'd0) ? PH_SUMHI : PH_DATA;
         end
         PH_DATA: begin
            result.payload_valid = 1'b1;
            result.payload_index = count_ff;
            result.payload_byte  = rx_byte;
            sum_in   = sum_ff + {8'd0, rx_byte};
            count_in = count_plus;
            if (count_plus >= length_ff) begin
               phase_in = PH_SUMHI;
            end
         end
         PH_SUMHI: begin
            sum_high_in = rx_byte;
            phase_in    = PH_SUMLO;
         end
         PH_SUMLO: begin
            sum_low_in = rx_byte;
            phase_in   = PH_END;
         end
         PH_END: begin
            if (rx_byte == END_MARK && {sum_high_ff, sum_low_ff} == sum_ff) begin
               decoded_in = 1'b1;
            end
            phase_in = PH_START;
         end
         default: begin
            phase_in = PH_START;
         end
      endcase
      result.frame_good   = decoded_in;
      result.frame_model  = model_in;
      result.frame_ident  = ident_in;
      result.frame_length = length_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_START;
         model_ff    <= 8'd0;
         ident_ff    <= 8'd0;
         length_ff   <= 8'd0;
         count_ff    <= 8'd0;
         sum_ff      <= 16'd0;
         sum_high_ff <= 8'd0;
         sum_low_ff  <= 8'd0;
         decoded_ff  <= 1'b0;
      end else if (take) begin
         phase_ff    <= phase_in;
         model_ff    <= model_in;
         ident_ff    <= ident_in;
         length_ff   <= length_in;
         count_ff    <= count_in;
         sum_ff      <= sum_in;
         sum_high_ff <= sum_high_in;
         sum_low_ff  <= sum_low_in;
         decoded_ff  <= decoded_in;
      end
   end

endmodule

// ----- rtl/core/fpcd_out_stage.sv -----
// Output register with a skid register for the decoder results, so that a
// new item is taken while a result waits. Depends on fpcd_pkg.
module fpcd_out_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  fpcd_pkg::result_type       push_data,
   output logic                       can_push,
   input  logic                       pop_ready,
   output logic                       out_valid,
   output fpcd_pkg::result_type       out_data,
   output fpcd_pkg::stage_status_type status
);
   import fpcd_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_data_ff, out_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       pop;

   assign pop = out_valid_ff & pop_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_data_in  = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign can_push          = !skid_valid_ff;
   assign out_valid         = out_valid_ff;
   assign out_data          = out_data_ff;
   assign status.out_valid  = out_valid_ff;
   assign status.skid_valid = skid_valid_ff;

endmodule

// ----- rtl/core/framed_packet_checksum_decoder.sv -----
// Framed packet checksum decoder: byte-serial frame parser with a 16-bit
// additive payload checksum. Depends on fpcd_pkg, fpcd_parser, fpcd_out_stage
// and the assertion macros in framed_packet_checksum_decoder_assert.svh.
//
// Usage: each item on the req_ channel is one received byte of a frame
// 0xAA, model, id, length, payload, checksum high, checksum low, 0x55.
// Every accepted byte gives exactly one item on the rsp_ channel: the decoded
// flag and header fields after that byte, and, for a payload byte, the byte
// and its index with rsp_tuser set.
// The result of an accepted byte is registered in the result register, or in
// the skid register while the receiver stalls. One byte is taken per cycle
// while req_tready is high; the result register and a skid register keep
// req_tready high while one result waits. When the receiver stalls, a second
// byte goes into the skid register and req_tready then drops until a result
// is taken. Synchronous reset returns the parser to waiting for a start byte,
// clears the header fields, counter, sum and decoded flag, and empties the
// output registers; nothing is delivered until new bytes arrive.
`include "framed_packet_checksum_decoder_assert.svh"

module framed_packet_checksum_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // rx_byte [7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // frame_good [0], frame_model [8:1], frame_ident [16:9], frame_length [24:17],
   // payload_index [32:25], payload_byte [40:33], zero fill [47:41]
   output logic [47:0] rsp_tdata,
   output logic        rsp_tuser   // payload_valid [0]
);
   import fpcd_pkg::*;

   logic             take;
   logic             can_push;
   result_type       parsed;
   result_type       held;
   stage_status_type stage_status;

   assign take       = req_tvalid & can_push;
   assign req_tready = can_push;

   fpcd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .rx_byte (req_tdata),
      .result  (parsed)
   );

   fpcd_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .push      (take),
      .push_data (parsed),
      .can_push  (can_push),
      .pop_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (held),
      .status    (stage_status)
   );

   assign rsp_tdata = {7'd0, held.payload_byte, held.payload_index, held.frame_length,
                       held.frame_ident, held.frame_model, held.frame_good};
   assign rsp_tuser = held.payload_valid;

   `FPCD_ASSERT_NEXT(a_result_follows, clock, reset, req_tvalid && req_tready, rsp_tvalid, "accepted byte gave no result")
   `FPCD_ASSERT_SAME(a_skid_needs_out, clock, reset, stage_status.skid_valid, stage_status.out_valid, "skid holds a result while the output register is empty")
   `FPCD_ASSERT_SAME(a_payload_not_good, clock, reset, rsp_tvalid && rsp_tuser, !rsp_tdata[0], "decoded flag set on a payload byte")

endmodule
